### design/ptc_pkg.sv
// Package for the barometric trim compensation block.
// Types, register indexes, opcodes and sequencer states; no dependencies.
package ptc_pkg;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TEMP_TRIM = 2'd0,
		REG_PRESS_A   = 2'd1,
		REG_PRESS_B   = 2'd2,
		REG_PRESS_C   = 2'd3
	} reg_idx_t;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [19:0] raw_sample;
	} in_word_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               divide_guard;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  cfg_index;
		logic [63:0] cfg_data;
	} cfg_word_t;

	// Sequencer states: idle, the temperature sequence and the pressure sequence
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_MUL_A, ST_T_MUL_D, ST_T_MUL_B, ST_T_FIN, ST_T_OUT,
		ST_P_V1SQ, ST_P_V2, ST_P_V1P5, ST_P_V1P3, ST_P_V1P2, ST_P_V1P1,
		ST_P_CHK, ST_P_NUM, ST_P_DIV, ST_P_DIVEND, ST_P_QQ, ST_P_Q9,
		ST_P_P8, ST_P_FIN, ST_OUT
	} state_t;

	// 64-bit wrapping product, built from 32x32 partial products over cycles
	typedef enum logic [1:0] {
		MP_LL, MP_LH, MP_HL
	} mphase_t;

endpackage

### design/ptc_if.sv
// Valid/ready channel interface used for the data and configuration ports.
// Depends on nothing; payload type is a parameter of the interface.
interface ptc_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/pressure_temperature_compensation.sv
// Top level of the barometric trim compensation block.
// Depends on ptc_pkg and ptc_if.
//
//  channel   role    word
//  cfg       sink    cfg_index (2b), cfg_data (64b)
//  in_ch     sink    operation, raw_sample
//  out_ch    source  result_kind, temperature_centi, pressure_q24_8, divide_guard
//
// One item at a time. Results come from the shared 32x32 multiplier (each 64-bit
// product: issue, three passes, hand-back) and the one-bit-a-cycle restoring
// divider (64 steps); a pressure word with a zero divisor skips the divider and
// the multiply steps after it.
// Reset clears trims and fine temperature. in_ch.ready is low while a word is
// in work or the result waits; a stalled result holds. cfg is always ready.
module pressure_temperature_compensation (
	input logic clk,
	input logic arst_n,
	ptc_if.sink cfg,
	ptc_if.sink in_ch,
	ptc_if.source out_ch
);

	ptc_pkg::state_t state_q, state_d;
	logic [47:0] temp_trim_q;
	logic [63:0] press_a_q, press_b_q;
	logic [15:0] press_c_q;
	logic [31:0] tfine_q;
	logic [19:0] adc_q;
	logic [63:0] ra_q, rb_q, rc_q, rd_q;
	logic [63:0] ma_q, mb_q, prod_q;
	ptc_pkg::mphase_t mph_q;
	logic        mstart, mbusy_q, mdone, mdone_q;
	logic [63:0] dnum_q, dden_q, dquo_q;
	logic [64:0] drem_q;
	logic [6:0]  dcnt_q;
	logic        dneg_q;
	logic        guard_q;
	ptc_pkg::out_word_t out_q;
	logic        out_valid_q;

	// trim fields
	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, temp_trim_q[15:0]};
	assign t2 = {{16{temp_trim_q[31]}}, temp_trim_q[31:16]};
	assign t3 = {{16{temp_trim_q[47]}}, temp_trim_q[47:32]};
	assign p1 = {48'd0, press_a_q[15:0]};
	assign p2 = {{48{press_a_q[31]}}, press_a_q[31:16]};
	assign p3 = {{48{press_a_q[47]}}, press_a_q[47:32]};
	assign p4 = {{48{press_a_q[63]}}, press_a_q[63:48]};
	assign p5 = {{48{press_b_q[15]}}, press_b_q[15:0]};
	assign p6 = {{48{press_b_q[31]}}, press_b_q[31:16]};
	assign p7 = {{48{press_b_q[47]}}, press_b_q[47:32]};
	assign p8 = {{48{press_b_q[63]}}, press_b_q[63:48]};
	assign p9 = {{48{press_c_q[15]}}, press_c_q};

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == ptc_pkg::ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
		end else if (cfg.valid) begin
			unique case (ptc_pkg::reg_idx_t'(cfg.data.cfg_index))
				ptc_pkg::REG_TEMP_TRIM: temp_trim_q <= cfg.data.cfg_data[47:0];
				ptc_pkg::REG_PRESS_A: press_a_q <= cfg.data.cfg_data;
				ptc_pkg::REG_PRESS_B: press_b_q <= cfg.data.cfg_data;
				ptc_pkg::REG_PRESS_C: press_c_q <= cfg.data.cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// shared multiplier: wrapping 64x64 low half from three 32x32 products
	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;
	always_comb begin
		case (mph_q)
			ptc_pkg::MP_LL: begin mul_x = ma_q[31:0]; mul_y = mb_q[31:0]; end
			ptc_pkg::MP_LH: begin mul_x = ma_q[31:0]; mul_y = mb_q[63:32]; end
			default: begin mul_x = ma_q[63:32]; mul_y = mb_q[31:0]; end
		endcase
	end
	assign mul_p = 64'(mul_x) * 64'(mul_y);
	assign mdone = mdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mph_q <= ptc_pkg::MP_LL;
		end else if (mstart) begin
			mbusy_q <= 1'b1;
			mph_q <= ptc_pkg::MP_LL;
		end else if (mbusy_q) begin
			case (mph_q)
				ptc_pkg::MP_LL: mph_q <= ptc_pkg::MP_LH;
				ptc_pkg::MP_LH: mph_q <= ptc_pkg::MP_HL;
				default: begin mbusy_q <= 1'b0; mph_q <= ptc_pkg::MP_LL; end
			endcase
		end
	end

	// done in the cycle after the last pass, once prod_q holds the whole product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mdone_q <= 1'b0;
		else
			mdone_q <= mbusy_q && (mph_q == ptc_pkg::MP_HL);
	end

	always_ff @(posedge clk) begin
		if (mbusy_q) begin
			case (mph_q)
				ptc_pkg::MP_LL: prod_q <= mul_p;
				default: prod_q <= prod_q + {mul_p[31:0], 32'd0};
			endcase
		end
	end

	// operand selection for the multiplier, per state
	logic [63:0] sel_a, sel_b;
	logic [31:0] tmp32a, tmp32d;
	assign tmp32a = {15'd0, adc_q[19:3]} - {t1[30:0], 1'b0};
	assign tmp32d = {16'd0, adc_q[19:4]} - t1;
	always_comb begin
		sel_a = '0;
		sel_b = '0;
		unique case (state_q)
			ptc_pkg::ST_T_MUL_A: begin
				sel_a = {32'd0, tmp32a}; sel_b = {32'd0, t2};
			end
			ptc_pkg::ST_T_MUL_D: begin
				sel_a = {32'd0, tmp32d}; sel_b = {32'd0, tmp32d};
			end
			ptc_pkg::ST_T_MUL_B: begin
				sel_a = {32'd0, 32'($signed(rb_q[31:0]) >>> 12)}; sel_b = {32'd0, t3};
			end
			ptc_pkg::ST_P_V1SQ: begin sel_a = ra_q; sel_b = ra_q; end
			ptc_pkg::ST_P_V2: begin sel_a = rb_q; sel_b = p6; end
			ptc_pkg::ST_P_V1P5: begin sel_a = ra_q; sel_b = p5; end
			ptc_pkg::ST_P_V1P3: begin sel_a = rb_q; sel_b = p3; end
			ptc_pkg::ST_P_V1P2: begin sel_a = ra_q; sel_b = p2; end
			ptc_pkg::ST_P_V1P1: begin sel_a = rd_q; sel_b = p1; end
			ptc_pkg::ST_P_NUM: begin sel_a = ra_q; sel_b = 64'd3125; end
			ptc_pkg::ST_P_QQ: begin sel_a = rb_q; sel_b = rb_q; end
			ptc_pkg::ST_P_Q9: begin sel_a = prod_q; sel_b = p9; end
			ptc_pkg::ST_P_P8: begin sel_a = p8; sel_b = ra_q; end
			default: ;
		endcase
	end

	// sequencer: each multiply state issues, then waits for mdone
	logic msent_q;

	always_comb begin
		state_d = state_q;
		mstart = 1'b0;
		unique case (state_q)
			ptc_pkg::ST_IDLE:
				if (in_ch.valid && in_ch.ready)
					state_d = in_ch.data.operation == ptc_pkg::OP_TEMP ?
						ptc_pkg::ST_T_MUL_A : ptc_pkg::ST_P_V1SQ;
			ptc_pkg::ST_T_MUL_A, ptc_pkg::ST_T_MUL_D, ptc_pkg::ST_T_MUL_B,
			ptc_pkg::ST_P_V1SQ, ptc_pkg::ST_P_V2, ptc_pkg::ST_P_V1P5,
			ptc_pkg::ST_P_V1P3, ptc_pkg::ST_P_V1P2, ptc_pkg::ST_P_V1P1,
			ptc_pkg::ST_P_NUM, ptc_pkg::ST_P_QQ, ptc_pkg::ST_P_Q9,
			ptc_pkg::ST_P_P8: begin
				mstart = !msent_q;
				if (mdone) begin
					unique case (state_q)
						ptc_pkg::ST_T_MUL_A: state_d = ptc_pkg::ST_T_MUL_D;
						ptc_pkg::ST_T_MUL_D: state_d = ptc_pkg::ST_T_MUL_B;
						ptc_pkg::ST_T_MUL_B: state_d = ptc_pkg::ST_T_FIN;
						ptc_pkg::ST_P_V1SQ: state_d = ptc_pkg::ST_P_V2;
						ptc_pkg::ST_P_V2: state_d = ptc_pkg::ST_P_V1P5;
						ptc_pkg::ST_P_V1P5: state_d = ptc_pkg::ST_P_V1P3;
						ptc_pkg::ST_P_V1P3: state_d = ptc_pkg::ST_P_V1P2;
						ptc_pkg::ST_P_V1P2: state_d = ptc_pkg::ST_P_V1P1;
						ptc_pkg::ST_P_V1P1: state_d = ptc_pkg::ST_P_CHK;
						ptc_pkg::ST_P_NUM: state_d = ptc_pkg::ST_P_DIV;
						ptc_pkg::ST_P_QQ: state_d = ptc_pkg::ST_P_Q9;
						ptc_pkg::ST_P_Q9: state_d = ptc_pkg::ST_P_P8;
						default: state_d = ptc_pkg::ST_P_FIN;
					endcase
				end
			end
			ptc_pkg::ST_T_FIN: state_d = ptc_pkg::ST_T_OUT;
			ptc_pkg::ST_T_OUT: state_d = ptc_pkg::ST_IDLE;
			ptc_pkg::ST_P_CHK:
				state_d = (ra_q == '0) ? ptc_pkg::ST_OUT : ptc_pkg::ST_P_NUM;
			ptc_pkg::ST_P_DIV:
				if (dcnt_q == 7'd63) state_d = ptc_pkg::ST_P_DIVEND;
			ptc_pkg::ST_P_DIVEND: state_d = ptc_pkg::ST_P_QQ;
			ptc_pkg::ST_P_FIN: state_d = ptc_pkg::ST_OUT;
			ptc_pkg::ST_OUT: state_d = ptc_pkg::ST_IDLE;
			default: state_d = ptc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptc_pkg::ST_IDLE;
			msent_q <= 1'b0;
		end else begin
			state_q <= state_d;
			msent_q <= (state_d == state_q) ? (msent_q | mstart) : 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mstart) begin
			ma_q <= sel_a;
			mb_q <= sel_b;
		end
	end

	// datapath registers
	logic [64:0] rem_sh, rem_sub;
	logic [63:0] pnum;
	assign rem_sh = {drem_q[63:0], dnum_q[63]};
	assign rem_sub = rem_sh - {1'b0, dden_q};
	assign pnum = 64'd1048576 - {44'd0, adc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tfine_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == ptc_pkg::ST_T_FIN)
				tfine_q <= ra_q[31:0] + 32'($signed(prod_q[31:0]) >>> 14);
			if (state_q == ptc_pkg::ST_T_OUT || state_q == ptc_pkg::ST_OUT)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptc_pkg::ST_IDLE && in_ch.valid && in_ch.ready) begin
			adc_q <= in_ch.data.raw_sample;
			ra_q <= {{32{tfine_q[31]}}, tfine_q} - 64'd128000;
		end
		if (mdone) begin
			unique case (state_q)
				ptc_pkg::ST_T_MUL_A: ra_q <= {32'd0, 32'($signed(prod_q[31:0]) >>> 11)};
				ptc_pkg::ST_T_MUL_D: rb_q <= prod_q;
				ptc_pkg::ST_P_V1SQ: rb_q <= prod_q;
				ptc_pkg::ST_P_V2: rc_q <= prod_q + {p4[28:0], 35'd0};
				ptc_pkg::ST_P_V1P5: rc_q <= rc_q + {prod_q[46:0], 17'd0};
				ptc_pkg::ST_P_V1P3: rd_q <= 64'($signed(prod_q) >>> 8);
				ptc_pkg::ST_P_V1P2:
					rd_q <= rd_q + {prod_q[51:0], 12'd0} + {17'd1, 47'd0};
				ptc_pkg::ST_P_V1P1: ra_q <= 64'($signed(prod_q) >>> 33);
				ptc_pkg::ST_P_QQ: ;
				ptc_pkg::ST_P_Q9: rc_q <= 64'($signed(prod_q) >>> 25);
				ptc_pkg::ST_P_P8: rd_q <= 64'($signed(prod_q) >>> 19);
				default: ;
			endcase
		end
		// divisor magnitude into dden and a copy into rd; numerator base into ra
		if (state_q == ptc_pkg::ST_P_CHK) begin
			ra_q <= {pnum[32:0], 31'd0} - rc_q;
			dden_q <= ra_q[63] ? (64'd0 - ra_q) : ra_q;
			rd_q <= ra_q;
			guard_q <= (ra_q == '0);
		end
		if (state_q == ptc_pkg::ST_P_NUM && mdone) begin
			dnum_q <= prod_q[63] ? (64'd0 - prod_q) : prod_q;
			dneg_q <= prod_q[63] ^ rd_q[63];
			drem_q <= '0;
			dcnt_q <= '0;
		end
		// restoring division, one quotient bit a cycle
		if (state_q == ptc_pkg::ST_P_DIV) begin
			dnum_q <= {dnum_q[62:0], 1'b0};
			dcnt_q <= dcnt_q + 7'd1;
			if (!rem_sub[64]) begin
				drem_q <= rem_sub;
				dquo_q <= {dquo_q[62:0], 1'b1};
			end else begin
				drem_q <= rem_sh;
				dquo_q <= {dquo_q[62:0], 1'b0};
			end
		end
		if (state_q == ptc_pkg::ST_P_DIVEND) begin
			ra_q <= dneg_q ? (64'd0 - dquo_q) : dquo_q;
			rb_q <= dneg_q ? 64'($signed(64'd0 - dquo_q) >>> 13)
				: 64'($signed(dquo_q) >>> 13);
		end
		if (state_q == ptc_pkg::ST_P_FIN)
			rb_q <= 64'($signed(ra_q + rc_q + rd_q) >>> 8) + {p7[59:0], 4'd0};
		// result word
		if (state_q == ptc_pkg::ST_T_OUT) begin
			out_q.result_kind <= ptc_pkg::OP_TEMP;
			out_q.temperature_centi <=
				32'($signed(tfine_q * 32'd5 + 32'd128) >>> 8);
			out_q.pressure_q24_8 <= '0;
			out_q.divide_guard <= 1'b0;
		end
		if (state_q == ptc_pkg::ST_OUT) begin
			out_q.result_kind <= ptc_pkg::OP_PRESS;
			out_q.temperature_centi <= '0;
			out_q.pressure_q24_8 <= guard_q ? 32'd0 : rb_q[31:0];
			out_q.divide_guard <= guard_q;
		end
	end

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ptc_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_mul_single: assert property (@(posedge clk) disable iff (!arst_n)
		mstart |-> !mbusy_q)
		else $error("multiplier restarted while busy");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptc_pkg::ST_P_DIV |-> dcnt_q < 7'd64)
		else $error("divider overran");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q)
		else $error("result dropped");

endmodule
